// ----- design/slbs_pkg.sv -----
// ----------------------------------------------------------------------------
// slbs_pkg
// Shared types and constants for the status LED blink sequencer: item codes,
// register map, sequencer phase encodings and the configuration bundle.
// ----------------------------------------------------------------------------
package slbs_pkg;

    // configuration field widths (fixed by the register map)
    localparam int CFG_TIME_W  = 16;
    localparam int CFG_COUNT_W = 8;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 5;
    localparam int REG_IDX_W   = 3;

    // item codes on the input channel
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_POLL = 2'd1,
        OP_TEST = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_START_TIME    = 3'd0,
        REG_NORMAL_BLINKS = 3'd1,
        REG_NORMAL_ON     = 3'd2,
        REG_NORMAL_OFF    = 3'd3,
        REG_FAULT_BLINKS  = 3'd4,
        REG_FAULT_ON      = 3'd5,
        REG_FAULT_OFF     = 3'd6,
        REG_LONG_OFF      = 3'd7
    } reg_idx_t;

    // register reset values
    localparam logic [CFG_TIME_W-1:0]  RST_START_TIME    = 16'd50;
    localparam logic [CFG_COUNT_W-1:0] RST_NORMAL_BLINKS = 8'd1;
    localparam logic [CFG_TIME_W-1:0]  RST_NORMAL_ON     = 16'd0;
    localparam logic [CFG_TIME_W-1:0]  RST_NORMAL_OFF    = 16'd100;
    localparam logic [CFG_COUNT_W-1:0] RST_FAULT_BLINKS  = 8'd2;
    localparam logic [CFG_TIME_W-1:0]  RST_FAULT_ON      = 16'd100;
    localparam logic [CFG_TIME_W-1:0]  RST_FAULT_OFF     = 16'd100;
    localparam logic [CFG_TIME_W-1:0]  RST_LONG_OFF      = 16'd1000;

    // start-up sequence phases
    typedef enum logic [1:0] {
        SP_IDLE    = 2'd0,
        SP_START   = 2'd1,
        SP_WAIT    = 2'd2,
        SP_OPERATE = 2'd3
    } startup_t;

    // blink state machine phases
    typedef enum logic [2:0] {
        BP_IDLE      = 3'd0,
        BP_LED_ON    = 3'd1,
        BP_ON_WAIT   = 3'd2,
        BP_OFF_WAIT  = 3'd3,
        BP_LONG_WAIT = 3'd4
    } blink_t;

    // pattern set chosen by the last poll
    typedef enum logic [1:0] {
        MODE_INITIAL = 2'd0,
        MODE_NORMAL  = 2'd1,
        MODE_FAULT   = 2'd2
    } mode_t;

    // live configuration seen by the sequencer
    typedef struct packed {
        logic [CFG_TIME_W-1:0]  start_time_ms;
        logic [CFG_COUNT_W-1:0] normal_blinks;
        logic [CFG_TIME_W-1:0]  normal_on_ms;
        logic [CFG_TIME_W-1:0]  normal_off_ms;
        logic [CFG_COUNT_W-1:0] fault_blinks;
        logic [CFG_TIME_W-1:0]  fault_on_ms;
        logic [CFG_TIME_W-1:0]  fault_off_ms;
        logic [CFG_TIME_W-1:0]  long_off_ms;
    } cfg_t;

    // outputs of the sequencer after an item
    typedef struct packed {
        logic led_level;
        logic test_active;
    } status_t;

endpackage

// ----- design/status_led_blink_sequencer.sv -----
// ----------------------------------------------------------------------------
// status_led_blink_sequencer
// Status LED pattern generator: start-up flash, then normal or fault blink
// groups with a long off gap, plus a sticky test override.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  s_        in         s_valid / s_ready  s_op, s_fault_present, s_test_level
//  m_        out        m_valid / m_ready  m_led_level, m_test_active
//  apb       in         psel/penable/pready  paddr, pwdata, prdata
//
//  one transfer per cycle sustained while m_ready stays high; each item
//  goes from acceptance to result via the input and then the result register
//  the sequencer state is updated as the item moves into the result register,
//  so the next item in the input register already sees it
//  a stalled result register holds the input register, which then holds
//  s_ready low; no transfer is dropped or repeated
//  aresetn is synchronous and active low; no clearing pass is needed
//
module status_led_blink_sequencer #(
    parameter int TIME_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // item channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_op,
    input  logic                             s_fault_present,
    input  logic                             s_test_level,

    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_led_level,
    output logic                             m_test_active,

    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [slbs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [slbs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [slbs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    slbs_pkg::cfg_t    cfg;
    slbs_pkg::status_t status_next;

    // input register
    logic              in_valid_reg;
    slbs_pkg::op_t     op_reg;
    logic              fault_reg;
    logic              level_reg;

    // result register
    logic              out_valid_reg;
    slbs_pkg::status_t out_status_reg;

    logic              advance;

    // the input stage moves on whenever the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            op_reg    <= slbs_pkg::op_t'(s_op);
            fault_reg <= s_fault_present;
            level_reg <= s_test_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_status_reg <= status_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_led_level   = out_status_reg.led_level;
    assign m_test_active = out_status_reg.test_active;

    slbs_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // state commits only on the cycle the item reaches the result register
    slbs_seq_core #(
        .TIME_BITS (TIME_BITS)
    ) u_seq_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (advance),
        .op            (op_reg),
        .fault_present (fault_reg),
        .test_level    (level_reg),
        .cfg           (cfg),
        .status_next   (status_next)
    );

    // a held input item must not be lost while the result stalls
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |=> (in_valid_reg && out_valid_reg))
        else $error("item lost while result stalled");

    // a result is only produced from a held input item
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!in_valid_reg && !(out_valid_reg && !m_ready)) |=> !out_valid_reg)
        else $error("result appeared without an input item");

    // the test flag in the result never drops once shown
    a_result_test_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg.test_active) |=>
            (!out_valid_reg || out_status_reg.test_active))
        else $error("test flag dropped in a later result");

endmodule

// ----- design/slbs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// slbs_cfg_regs
// APB register file holding the blink timing and count settings.
// ----------------------------------------------------------------------------
module slbs_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [slbs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [slbs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [slbs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output slbs_pkg::cfg_t                   cfg
);

    slbs_pkg::cfg_t     cfg_reg;
    slbs_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = slbs_pkg::reg_idx_t'(paddr[slbs_pkg::APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_time_ms <= slbs_pkg::RST_START_TIME;
            cfg_reg.normal_blinks <= slbs_pkg::RST_NORMAL_BLINKS;
            cfg_reg.normal_on_ms  <= slbs_pkg::RST_NORMAL_ON;
            cfg_reg.normal_off_ms <= slbs_pkg::RST_NORMAL_OFF;
            cfg_reg.fault_blinks  <= slbs_pkg::RST_FAULT_BLINKS;
            cfg_reg.fault_on_ms   <= slbs_pkg::RST_FAULT_ON;
            cfg_reg.fault_off_ms  <= slbs_pkg::RST_FAULT_OFF;
            cfg_reg.long_off_ms   <= slbs_pkg::RST_LONG_OFF;
        end else if (wr_en) begin
            case (idx)
                slbs_pkg::REG_START_TIME: begin
                    cfg_reg.start_time_ms <= pwdata[slbs_pkg::CFG_TIME_W-1:0];
                end
                slbs_pkg::REG_NORMAL_BLINKS: begin
                    cfg_reg.normal_blinks <= pwdata[slbs_pkg::CFG_COUNT_W-1:0];
                end
                slbs_pkg::REG_NORMAL_ON: begin
                    cfg_reg.normal_on_ms <= pwdata[slbs_pkg::CFG_TIME_W-1:0];
                end
                slbs_pkg::REG_NORMAL_OFF: begin
                    cfg_reg.normal_off_ms <= pwdata[slbs_pkg::CFG_TIME_W-1:0];
                end
                slbs_pkg::REG_FAULT_BLINKS: begin
                    cfg_reg.fault_blinks <= pwdata[slbs_pkg::CFG_COUNT_W-1:0];
                end
                slbs_pkg::REG_FAULT_ON: begin
                    cfg_reg.fault_on_ms <= pwdata[slbs_pkg::CFG_TIME_W-1:0];
                end
                slbs_pkg::REG_FAULT_OFF: begin
                    cfg_reg.fault_off_ms <= pwdata[slbs_pkg::CFG_TIME_W-1:0];
                end
                slbs_pkg::REG_LONG_OFF: begin
                    cfg_reg.long_off_ms <= pwdata[slbs_pkg::CFG_TIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // read-back, zero extended
    always_comb begin
        case (idx)
            slbs_pkg::REG_START_TIME:    prdata = 32'(cfg_reg.start_time_ms);
            slbs_pkg::REG_NORMAL_BLINKS: prdata = 32'(cfg_reg.normal_blinks);
            slbs_pkg::REG_NORMAL_ON:     prdata = 32'(cfg_reg.normal_on_ms);
            slbs_pkg::REG_NORMAL_OFF:    prdata = 32'(cfg_reg.normal_off_ms);
            slbs_pkg::REG_FAULT_BLINKS:  prdata = 32'(cfg_reg.fault_blinks);
            slbs_pkg::REG_FAULT_ON:      prdata = 32'(cfg_reg.fault_on_ms);
            slbs_pkg::REG_FAULT_OFF:     prdata = 32'(cfg_reg.fault_off_ms);
            slbs_pkg::REG_LONG_OFF:      prdata = 32'(cfg_reg.long_off_ms);
            default:                     prdata = '0;
        endcase
    end

endmodule

// ----- design/slbs_seq_core.sv -----
// ----------------------------------------------------------------------------
// slbs_seq_core
// Sequencer state and its single-step update: one-shot timer, start-up
// flash, blink state machine and the sticky test override.
// ----------------------------------------------------------------------------
module slbs_seq_core #(
    parameter int TIME_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  slbs_pkg::op_t      op,
    input  logic               fault_present,
    input  logic               test_level,
    input  slbs_pkg::cfg_t     cfg,
    output slbs_pkg::status_t  status_next
);

    localparam logic [32:0] TIME_MAX = (33'd1 << TIME_BITS) - 33'd1;

    slbs_pkg::startup_t startup_reg, startup_next;
    slbs_pkg::blink_t   blink_reg, blink_next;
    slbs_pkg::mode_t    mode_reg, mode_next;
    logic [slbs_pkg::CFG_COUNT_W-1:0] blinks_done_reg, blinks_done_next;
    logic [TIME_BITS-1:0]             timer_count_reg, timer_count_next;
    logic timer_expired_reg, timer_expired_next;
    logic test_reg, test_next;
    logic led_reg, led_next;

    logic                             load_en;
    logic [slbs_pkg::CFG_TIME_W-1:0]  load_val;
    logic                             use_fault;
    logic [slbs_pkg::CFG_COUNT_W-1:0] blinks_sel;
    logic [slbs_pkg::CFG_TIME_W-1:0]  on_sel;
    logic [slbs_pkg::CFG_TIME_W-1:0]  off_sel;
    logic [slbs_pkg::CFG_COUNT_W-1:0] done_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            startup_reg       <= slbs_pkg::SP_IDLE;
            blink_reg         <= slbs_pkg::BP_IDLE;
            mode_reg          <= slbs_pkg::MODE_INITIAL;
            blinks_done_reg   <= '0;
            timer_count_reg   <= '0;
            timer_expired_reg <= 1'b0;
            test_reg          <= 1'b0;
            led_reg           <= 1'b0;
        end else if (fire) begin
            startup_reg       <= startup_next;
            blink_reg         <= blink_next;
            mode_reg          <= mode_next;
            blinks_done_reg   <= blinks_done_next;
            timer_count_reg   <= timer_count_next;
            timer_expired_reg <= timer_expired_next;
            test_reg          <= test_next;
            led_reg           <= led_next;
        end
    end

    // pattern set follows the fault flag of the current poll
    assign use_fault  = fault_present;
    assign blinks_sel = use_fault ? cfg.fault_blinks : cfg.normal_blinks;
    assign on_sel     = use_fault ? cfg.fault_on_ms  : cfg.normal_on_ms;
    assign off_sel    = use_fault ? cfg.fault_off_ms : cfg.normal_off_ms;
    assign done_inc   = blinks_done_reg + 8'd1;

    always_comb begin
        startup_next     = startup_reg;
        blink_next       = blink_reg;
        mode_next        = mode_reg;
        blinks_done_next = blinks_done_reg;
        test_next        = test_reg;
        led_next         = led_reg;
        load_en          = 1'b0;
        load_val         = '0;

        case (op)
            slbs_pkg::OP_POLL: begin
                if (!test_reg) begin
                    case (startup_reg)
                        slbs_pkg::SP_IDLE: begin
                            led_next     = 1'b1;
                            startup_next = slbs_pkg::SP_START;
                        end
                        slbs_pkg::SP_START: begin
                            led_next     = 1'b1;
                            load_en      = 1'b1;
                            load_val     = cfg.start_time_ms;
                            startup_next = slbs_pkg::SP_WAIT;
                        end
                        slbs_pkg::SP_WAIT: begin
                            if (timer_expired_reg) begin
                                led_next     = 1'b0;
                                startup_next = slbs_pkg::SP_OPERATE;
                            end
                        end
                        default: begin
                            mode_next = use_fault ? slbs_pkg::MODE_FAULT
                                                  : slbs_pkg::MODE_NORMAL;
                            case (blink_reg)
                                slbs_pkg::BP_IDLE: begin
                                    led_next         = 1'b0;
                                    blink_next       = slbs_pkg::BP_LED_ON;
                                    blinks_done_next = '0;
                                end
                                slbs_pkg::BP_LED_ON: begin
                                    if (on_sel != '0) begin
                                        led_next   = 1'b1;
                                        load_en    = 1'b1;
                                        load_val   = on_sel;
                                        blink_next = slbs_pkg::BP_ON_WAIT;
                                    end
                                end
                                slbs_pkg::BP_ON_WAIT: begin
                                    if (timer_expired_reg && off_sel != '0) begin
                                        led_next   = 1'b0;
                                        load_en    = 1'b1;
                                        load_val   = off_sel;
                                        blink_next = slbs_pkg::BP_OFF_WAIT;
                                    end
                                end
                                slbs_pkg::BP_OFF_WAIT: begin
                                    if (timer_expired_reg) begin
                                        blinks_done_next = done_inc;
                                        if (done_inc < blinks_sel) begin
                                            blink_next = slbs_pkg::BP_LED_ON;
                                        end else if (cfg.long_off_ms != '0) begin
                                            led_next   = 1'b0;
                                            load_en    = 1'b1;
                                            load_val   = cfg.long_off_ms;
                                            blink_next = slbs_pkg::BP_LONG_WAIT;
                                        end else begin
                                            blink_next = slbs_pkg::BP_IDLE;
                                        end
                                    end
                                end
                                slbs_pkg::BP_LONG_WAIT: begin
                                    if (timer_expired_reg) begin
                                        blink_next = slbs_pkg::BP_IDLE;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    endcase
                end
            end
            slbs_pkg::OP_TEST: begin
                test_next = 1'b1;
                led_next  = test_level;
            end
            default: begin
            end
        endcase
    end

    // one-shot timer: ticks count down, loads saturate at the counter width
    always_comb begin
        timer_count_next   = timer_count_reg;
        timer_expired_next = timer_expired_reg;
        if (op == slbs_pkg::OP_TICK) begin
            if (timer_count_reg != '0) begin
                timer_count_next   = timer_count_reg - TIME_BITS'(1);
                timer_expired_next = (timer_count_reg == TIME_BITS'(1));
            end
        end else if (load_en) begin
            if (load_val == '0) begin
                timer_count_next   = '0;
                timer_expired_next = 1'b1;
            end else begin
                if (33'(load_val) > TIME_MAX) begin
                    timer_count_next = TIME_BITS'(TIME_MAX);
                end else begin
                    timer_count_next = TIME_BITS'(load_val);
                end
                timer_expired_next = 1'b0;
            end
        end
    end

    assign status_next.led_level   = led_next;
    assign status_next.test_active = test_next;

    // an expired timer always rests at zero
    a_expired_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        timer_expired_reg |-> (timer_count_reg == '0))
        else $error("timer flagged expired with a non-zero count");

    // the test override never clears once taken
    a_test_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        test_reg |=> test_reg)
        else $error("test override released");

    // the blink machine only leaves idle once start-up is complete
    a_blink_operate: assert property (@(posedge aclk) disable iff (!aresetn)
        (blink_reg != slbs_pkg::BP_IDLE) |-> (startup_reg == slbs_pkg::SP_OPERATE))
        else $error("blink phase active before operation");

    // mode is only chosen in operation
    a_mode_operate: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != slbs_pkg::MODE_INITIAL) |-> (startup_reg == slbs_pkg::SP_OPERATE))
        else $error("pattern set chosen before operation");

endmodule
